### sv/ffa_pkg.sv
// Package: payload structs, status codes and FSM states for the allocator.
`timescale 1ns / 1ps
package ffa_pkg;

  typedef struct packed {
    logic        op;
    logic [15:0] request_size;
    logic [7:0]  alignment;
    logic [15:0] release_offset;
  } req_t;

  typedef struct packed {
    logic [15:0] result_offset;
    logic [2:0]  status;
    logic [16:0] used_bytes;
    logic [4:0]  live_allocations;
  } rsp_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_SIZE = 3'd1,
    ST_BAD_ALIGN = 3'd2,
    ST_NO_FIT  = 3'd3,
    ST_NULL    = 3'd4,
    ST_UNKNOWN = 3'd5,
    ST_FULL    = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_A_RD,
    S_A_CHK,
    S_A_TAKE,
    S_SHL_RD,
    S_SHL_WR,
    S_F_REC,
    S_F_RD,
    S_F_CHK,
    S_F_PREV,
    S_SHR_RD,
    S_SHR_WR,
    S_DONE
  } state_e;

  // Front gap in front of a request placed into a block starting at s.
  function automatic logic [16:0] front_gap(input logic [15:0] s, input logic [7:0] a,
                                            input logic [6:0] hdr);
    logic [16:0] m;
    logic [16:0] adj;
    logic [16:0] need;
    m    = {9'd0, a} - 17'd1;
    adj  = (({1'b0, s} + m) & ~m) - {1'b0, s};
    need = 17'd0;
    if (adj < {10'd0, hdr}) begin
      need = (({10'd0, hdr} - adj) + m) & ~m;
    end
    return adj + need;
  endfunction

endpackage

### sv/ffa_free_mem.sv
// Free-block table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module ffa_free_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [32:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [32:0]   rdata_o
);
  logic [32:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### sv/ffa_rec_mem.sv
// Allocation record memory: offset, length and padding per slot.
`timescale 1ns / 1ps
module ffa_rec_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [40:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [40:0]   rdata_o
);
  logic [40:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### sv/first_fit_free_list_allocator.sv
// Top level: first-fit allocator sequencer over free-table and record memories.
//
//  channel   | ports                          | direction
//  request   | start, busy, req_i             | in (busy out)
//  result    | done_o, rsp_o                  | out
//  config    | cfg_we_i, cfg_data_i           | in
//
// An allocate walks the free table one entry at a time, then shifts entries down
// when a block is consumed. A free scans record slots one a cycle, walks the free
// table, then shifts entries when a merge or an insert needs it. A request with a bad
// field answers in the next cycle. Each result beat is followed by a return to idle.
// After reset or an arena write the free table is cleared one entry a cycle, with
// entry zero seeded from the arena, while busy is high. Results cannot be stalled.
`timescale 1ns / 1ps
module first_fit_free_list_allocator #(
  parameter int unsigned MAX_FREE_BLOCKS = 16,
  parameter int unsigned MAX_RECORDS     = 16,
  parameter int unsigned HEADER_BYTES    = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ffa_pkg::req_t req_i,
  output logic          done_o,
  output ffa_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [16:0]   cfg_data_i
);
  import ffa_pkg::*;

  localparam int unsigned FAW = (MAX_FREE_BLOCKS > 1) ? $clog2(MAX_FREE_BLOCKS) : 1;
  localparam int unsigned RAW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned FCW = $clog2(MAX_FREE_BLOCKS + 1);
  localparam int unsigned RCW = $clog2(MAX_RECORDS + 1);
  localparam logic [6:0]  HDR = 7'(HEADER_BYTES);
  localparam logic [FCW-1:0] FMAX = FCW'(MAX_FREE_BLOCKS);
  localparam logic [FCW-1:0] FONE = FCW'(1);
  localparam logic [RCW-1:0] RONE = RCW'(1);

  state_e state_q, state_d;
  logic [16:0] arena_q, arena_d;
  logic [FCW-1:0] fcnt_q, fcnt_d;
  logic [FCW-1:0] idx_q, idx_d;       // walk index and shift cursor
  logic [RCW-1:0] rix_q, rix_d;
  logic [MAX_RECORDS-1:0] rvalid_q, rvalid_d;
  logic [16:0] used_q, used_d;
  logic [4:0]  live_q, live_d;
  req_t        req_q, req_d;
  logic [2:0]  st_q, st_d;
  logic [15:0] off_q, off_d;
  logic [RAW-1:0] slot_q, slot_d;
  logic [15:0] fst_q, fst_d;          // start of freed block
  logic [16:0] fsz_q, fsz_d;          // size of freed block
  logic [32:0] prev_q, prev_d;        // previous entry seen during walk
  logic [32:0] hold_q, hold_d;        // entry after the freed block; carried during a right shift

  logic          f_we;
  logic [FAW-1:0] f_wa, f_ra;
  logic [32:0]   f_wd, f_rd;
  logic          r_we;
  logic [RAW-1:0] r_wa, r_ra;
  logic [40:0]   r_wd, r_rd;

  ffa_free_mem #(.Depth(MAX_FREE_BLOCKS), .AW(FAW)) u_free (
    .clk_i, .we_i(f_we), .waddr_i(f_wa), .wdata_i(f_wd), .raddr_i(f_ra), .rdata_o(f_rd)
  );
  ffa_rec_mem #(.Depth(MAX_RECORDS), .AW(RAW)) u_rec (
    .clk_i, .we_i(r_we), .waddr_i(r_wa), .wdata_i(r_wd), .raddr_i(r_ra), .rdata_o(r_rd)
  );

  logic [15:0] e_s;
  logic [16:0] e_l, gap, tot, rest;
  logic        any_slot;
  logic [RAW-1:0] free_slot;
  logic [16:0] cfg_v;
  logic        jp, jn;

  assign e_s  = f_rd[32:17];
  assign e_l  = f_rd[16:0];
  assign gap  = front_gap(e_s, req_q.alignment, HDR);
  assign tot  = gap + {1'b0, req_q.request_size};
  assign rest = e_l - tot;

  // idx = insertion point; hold valid when idx < count
  assign jp = (idx_q != '0) &&
              (({1'b0, prev_q[32:17]} + prev_q[16:0]) == {1'b0, fst_q});
  assign jn = (idx_q < fcnt_q) && ({1'b0, hold_q[32:17]} == ({1'b0, fst_q} + fsz_q));

  always_comb begin
    any_slot  = 1'b0;
    free_slot = '0;
    for (int i = MAX_RECORDS - 1; i >= 0; i--) begin
      if (!rvalid_q[i]) begin
        any_slot  = 1'b1;
        free_slot = RAW'(i);
      end
    end
  end

  assign cfg_v = (cfg_data_i == 17'd0) ? 17'd1 :
                 (cfg_data_i > 17'd65536) ? 17'd65536 : cfg_data_i;

  always_comb begin
    state_d = state_q; arena_d = arena_q; fcnt_d = fcnt_q; idx_d = idx_q;
    rix_d = rix_q; rvalid_d = rvalid_q; used_d = used_q; live_d = live_q; req_d = req_q;
    st_d = st_q; off_d = off_q; slot_d = slot_q; fst_d = fst_q; fsz_d = fsz_q;
    prev_d = prev_q; hold_d = hold_q;
    f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = idx_q[FAW-1:0];
    r_we = 1'b0; r_wa = slot_q; r_wd = '0; r_ra = rix_q[RAW-1:0];
    done_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d = req_i; off_d = '0; idx_d = '0; rix_d = '0;
          if (req_i.op == OP_ALLOC) begin
            if (req_i.request_size == 16'd0) begin
              st_d = ST_BAD_SIZE; state_d = S_DONE;
            end else if (req_i.alignment == 8'd0 ||
                         (req_i.alignment & (req_i.alignment - 8'd1)) != 8'd0) begin
              st_d = ST_BAD_ALIGN; state_d = S_DONE;
            end else begin
              state_d = S_A_RD;
            end
          end else if (req_i.release_offset == 16'd0) begin
            st_d = ST_NULL; state_d = S_DONE;
          end else begin
            state_d = S_F_REC;
          end
        end
      end
      S_INIT: begin
        // seed entry zero, then clear the rest of the table
        f_we = 1'b1; f_wa = idx_q[FAW-1:0];
        f_wd = (idx_q == '0) ? {16'd0, arena_q} : 33'd0;
        idx_d = idx_q + FONE;
        if (idx_q == FMAX - FONE) state_d = S_IDLE;
      end
      S_A_RD: begin
        if (idx_q >= fcnt_q) begin
          st_d = ST_NO_FIT; state_d = S_DONE;
        end else begin
          state_d = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (tot > e_l) begin
          idx_d = idx_q + FONE; state_d = S_A_RD;
        end else if (!any_slot) begin
          st_d = ST_FULL; state_d = S_DONE;
        end else begin
          off_d = e_s + gap[15:0];
          st_d  = ST_OK;
          r_we = 1'b1; r_wa = free_slot;
          rvalid_d[free_slot] = 1'b1;
          live_d = live_q + 5'd1;
          if (rest <= {10'd0, HDR}) begin
            r_wd = {e_s + gap[15:0], e_l, gap[7:0]};
            used_d = used_q + e_l;
            fcnt_d = fcnt_q - FONE;
            idx_d  = idx_q + FONE;
            state_d = S_SHL_RD;
          end else begin
            r_wd = {e_s + gap[15:0], tot, gap[7:0]};
            used_d = used_q + tot;
            f_we = 1'b1; f_wa = idx_q[FAW-1:0];
            f_wd = {e_s + tot[15:0], rest};
            state_d = S_DONE;
          end
        end
      end
      // left shift: entry idx moves to idx-1, for idx up to old count-1
      S_SHL_RD: begin
        if (idx_q > fcnt_q || idx_q >= FMAX) state_d = S_DONE;
        else state_d = S_SHL_WR;
      end
      S_SHL_WR: begin
        f_we = 1'b1; f_wa = FAW'(idx_q - FONE); f_wd = f_rd;
        idx_d = idx_q + FONE; state_d = S_SHL_RD;
      end
      S_F_REC: begin
        // scan records; data for slot rix-1 arrives now
        if (rix_q != '0 && rvalid_q[RAW'(rix_q - RONE)] &&
            r_rd[40:25] == req_q.release_offset) begin
          slot_d = RAW'(rix_q - RONE);
          fst_d  = r_rd[40:25] - {8'd0, r_rd[7:0]};
          fsz_d  = r_rd[24:8];
          idx_d  = '0;
          prev_d = '0;
          state_d = S_F_RD;
        end else if (rix_q == RCW'(MAX_RECORDS)) begin
          st_d = ST_UNKNOWN; state_d = S_DONE;
        end else begin
          rix_d = rix_q + RONE;
        end
      end
      S_F_RD: begin
        if (idx_q >= fcnt_q) state_d = S_F_PREV;
        else state_d = S_F_CHK;
      end
      S_F_CHK: begin
        if ({1'b0, e_s} >= {1'b0, fst_q} + fsz_q) begin
          hold_d = f_rd; state_d = S_F_PREV;
        end else begin
          prev_d = f_rd; idx_d = idx_q + FONE; state_d = S_F_RD;
        end
      end
      S_F_PREV: begin
        st_d = ST_OK;
        if (!jp && !jn && fcnt_q >= FMAX) begin
          st_d = ST_FULL; state_d = S_DONE;
        end else begin
          rvalid_d[slot_q] = 1'b0;
          used_d = used_q - fsz_q;
          if (live_q != '0) live_d = live_q - 5'd1;
          if (jp && jn) begin
            f_we = 1'b1; f_wa = FAW'(idx_q - FONE);
            f_wd = {prev_q[32:17], prev_q[16:0] + fsz_q + hold_q[16:0]};
            fcnt_d = fcnt_q - FONE; idx_d = idx_q + FONE; state_d = S_SHL_RD;
          end else if (jp) begin
            f_we = 1'b1; f_wa = FAW'(idx_q - FONE);
            f_wd = {prev_q[32:17], prev_q[16:0] + fsz_q};
            state_d = S_DONE;
          end else if (jn) begin
            f_we = 1'b1; f_wa = idx_q[FAW-1:0];
            f_wd = {fst_q, hold_q[16:0] + fsz_q};
            state_d = S_DONE;
          end else begin
            // insert at idx, carry old entries rightward
            f_we = 1'b1; f_wa = idx_q[FAW-1:0]; f_wd = {fst_q, fsz_q};
            fcnt_d = fcnt_q + FONE;
            idx_d = idx_q + FONE;
            state_d = (idx_q < fcnt_q) ? S_SHR_RD : S_DONE;
          end
        end
      end
      S_SHR_RD: begin
        // hold = entry that belongs at idx; fetch current idx first
        if (idx_q >= fcnt_q) state_d = S_DONE;
        else state_d = S_SHR_WR;
      end
      S_SHR_WR: begin
        f_we = 1'b1; f_wa = idx_q[FAW-1:0]; f_wd = hold_q;
        hold_d = f_rd; idx_d = idx_q + FONE; state_d = S_SHR_RD;
      end
      S_DONE: begin
        done_o = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (cfg_we_i) begin
      arena_d = cfg_v; fcnt_d = FONE; rvalid_d = '0; used_d = '0; live_d = '0;
      idx_d = '0; state_d = S_INIT;
    end
  end

  assign busy = (state_q != S_IDLE);
  assign rsp_o = {off_q, st_q, used_q, live_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; arena_q <= 17'd4096; fcnt_q <= FONE; idx_q <= '0;
      rvalid_q <= '0; used_q <= '0; live_q <= '0;
    end else begin
      state_q <= state_d; arena_q <= arena_d; fcnt_q <= fcnt_d; idx_q <= idx_d;
      rvalid_q <= rvalid_d; used_q <= used_d; live_q <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rix_q <= rix_d; req_q <= req_d; st_q <= st_d; off_q <= off_d;
    slot_q <= slot_d; fst_q <= fst_d; fsz_q <= fsz_d; prev_q <= prev_d; hold_q <= hold_d;
  end
endmodule
